>>> rtl/acm_pkg.sv
// shared types and constants of the keyword matcher
// no dependencies; imported by the engine, the top level, both checkers and the testbench
`default_nettype none

package acm_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int ALPHABET_DEF  = 256;
    localparam int BYTE_W        = 8;
    localparam int BYTE_N        = 2 ** BYTE_W;
    localparam int COUNT_W       = 16;
    localparam int TAG_W         = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TAG_W-1:0]   TAG_LAST  = '1;
    localparam logic [TAG_W-1:0]   TAG_FIRST = TAG_W'(1);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_BUILD  = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_BUILT = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BUILT     = 2'd3
    } status_t;

    typedef struct packed {
        req_type_t         req_type;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } acm_req_t;

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] match_count;
        logic               string_done;
    } acm_res_t;

endpackage

`default_nettype wire

>>> rtl/acm_engine.sv
// sequencer of the matcher: child table and node table memories with
// read-modify-write control for insert, breadth first build and query
// depends on acm_pkg
`default_nettype none

module acm_engine
    import acm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     stop_at_first,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire acm_req_t req_in,
    output logic          res_valid,
    input  wire logic     res_ready,
    output acm_res_t      res_out
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int SW    = $clog2(ALPHABET);
    localparam int DEPTH = MAX_NODES * ALPHABET;
    localparam int CAW   = $clog2(DEPTH);

    localparam logic [CAW-1:0] CLR_LAST   = CAW'(DEPTH - 1);
    localparam logic [CAW-1:0] CLR_NODES  = CAW'(MAX_NODES);
    localparam logic [CAW-1:0] SWEEP_LAST = CAW'(MAX_NODES - 1);
    localparam logic [NW:0]    NODES_FULL = (NW+1)'(MAX_NODES);
    localparam logic [SW:0]    SYM_END    = (SW+1)'(ALPHABET);

    typedef struct packed {
        logic [NW-1:0]      fail;
        logic [COUNT_W-1:0] cnt;
        logic [TAG_W-1:0]   tag;
        logic [NW-1:0]      qent;
    } node_t;

    typedef struct packed {
        logic fail;
        logic cnt;
        logic tag;
        logic qent;
    } node_we_t;

    typedef enum logic [24:0] {
        S_CLEAR     = 25'd1 << 0,
        S_IDLE      = 25'd1 << 1,
        S_INS_RD    = 25'd1 << 2,
        S_INS_CHK   = 25'd1 << 3,
        S_INS_CNT   = 25'd1 << 4,
        S_BLD_INIT  = 25'd1 << 5,
        S_BLD_POP   = 25'd1 << 6,
        S_BLD_NODE  = 25'd1 << 7,
        S_BLD_FL    = 25'd1 << 8,
        S_BLD_KID   = 25'd1 << 9,
        S_BLD_KIDD  = 25'd1 << 10,
        S_BLD_WALK  = 25'd1 << 11,
        S_BLD_WALKD = 25'd1 << 12,
        S_BLD_WALKF = 25'd1 << 13,
        S_BLD_TGT   = 25'd1 << 14,
        S_BLD_SETF  = 25'd1 << 15,
        S_BLD_PUSH  = 25'd1 << 16,
        S_Q_WALK    = 25'd1 << 17,
        S_Q_WD      = 25'd1 << 18,
        S_Q_WF      = 25'd1 << 19,
        S_Q_GOT     = 25'd1 << 20,
        S_Q_T       = 25'd1 << 21,
        S_Q_TD      = 25'd1 << 22,
        S_SWEEP     = 25'd1 << 23,
        S_RESP      = 25'd1 << 24
    } state_t;

    // byte folded into the alphabet, worked out at elaboration
    logic [SW-1:0] sym_lut [BYTE_N];
    for (genvar g = 0; g < BYTE_N; g++) begin : g_sym
        assign sym_lut[g] = SW'(g % ALPHABET);
    end

    // control state
    state_t             state_reg,   state_next;
    logic [CAW-1:0]     clr_reg,     clr_next;
    logic [NW-1:0]      ins_cur_reg, ins_cur_next;
    logic [NW-1:0]      qry_cur_reg, qry_cur_next;
    logic [NW:0]        nodes_reg,   nodes_next;
    logic [COUNT_W-1:0] total_reg,   total_next;
    logic               built_reg,   built_next;
    logic               stopped_reg, stopped_next;
    logic               broken_reg,  broken_next;
    logic [TAG_W-1:0]   epoch_reg,   epoch_next;
    logic [NW:0]        head_reg,    head_next;
    logic [NW:0]        tail_reg,    tail_next;
    logic [SW:0]        c_reg,       c_next;

    // payload
    acm_req_t      req_reg,   req_next;
    logic [SW-1:0] sym_reg,   sym_next;
    acm_res_t      res_reg,   res_next;
    logic [NW-1:0] f_reg,     f_next;
    logic [NW-1:0] bnode_reg, bnode_next;
    logic [NW-1:0] fnode_reg, fnode_next;
    logic [NW-1:0] ch_reg,    ch_next;
    logic [NW-1:0] tgt_reg,   tgt_next;

    // memory ports
    logic           ch_re, ch_we;
    logic [NW-1:0]  cm_node;
    logic [SW-1:0]  cm_sym;
    logic [CAW-1:0] mul_addr, ch_waddr;
    logic [NW-1:0]  ch_wdata, child_q;
    logic           nd_re;
    node_we_t       nd_we;
    logic [NW-1:0]  nd_raddr, nd_waddr;
    node_t          nd_wdata, node_q;

    logic [COUNT_W:0]   sum_wide;
    logic [COUNT_W-1:0] tot_sat, cnt_inc;
    logic [NW-1:0]      nx;
    logic               qclr;

    logic [NW-1:0] child_mem [DEPTH];
    node_t         node_mem  [MAX_NODES];

    assign mul_addr = CAW'(cm_node) * CAW'(ALPHABET) + CAW'(cm_sym);
    assign ch_waddr = (state_reg == S_CLEAR) ? clr_reg : mul_addr;

    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            child_mem[ch_waddr] <= ch_wdata;
        end
        if (ch_re)
        begin
            child_q <= child_mem[mul_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nd_we.fail)
        begin
            node_mem[nd_waddr].fail <= nd_wdata.fail;
        end
        if (nd_we.cnt)
        begin
            node_mem[nd_waddr].cnt <= nd_wdata.cnt;
        end
        if (nd_we.tag)
        begin
            node_mem[nd_waddr].tag <= nd_wdata.tag;
        end
        if (nd_we.qent)
        begin
            node_mem[nd_waddr].qent <= nd_wdata.qent;
        end
        if (nd_re)
        begin
            node_q <= node_mem[nd_raddr];
        end
    end

    assign sum_wide = {1'b0, total_reg} + {1'b0, node_q.cnt};
    assign tot_sat  = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
    assign cnt_inc  = (node_q.cnt == COUNT_MAX) ? node_q.cnt : node_q.cnt + COUNT_W'(1);
    assign nx       = (child_q != '0) ? child_q : nodes_reg[NW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        ins_cur_next = ins_cur_reg;
        qry_cur_next = qry_cur_reg;
        nodes_next   = nodes_reg;
        total_next   = total_reg;
        built_next   = built_reg;
        stopped_next = stopped_reg;
        broken_next  = broken_reg;
        epoch_next   = epoch_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        c_next       = c_reg;
        req_next     = req_reg;
        sym_next     = sym_reg;
        res_next     = res_reg;
        f_next       = f_reg;
        bnode_next   = bnode_reg;
        fnode_next   = fnode_reg;
        ch_next      = ch_reg;
        tgt_next     = tgt_reg;
        ch_re        = 1'b0;
        ch_we        = 1'b0;
        ch_wdata     = '0;
        cm_node      = f_reg;
        cm_sym       = sym_reg;
        nd_re        = 1'b0;
        nd_we        = '0;
        nd_raddr     = f_reg;
        nd_waddr     = f_reg;
        nd_wdata     = '0;
        qclr         = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ch_we = 1'b1;
                if (clr_reg < CLR_NODES)
                begin
                    nd_we    = '1;
                    nd_waddr = clr_reg[NW-1:0];
                end
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CAW'(1);
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_in;
                    sym_next = sym_lut[req_in.data_byte];
                    unique case (req_in.req_type)
                        REQ_INSERT:
                        begin
                            built_next = 1'b0;
                            if (broken_reg)
                            begin
                                res_next.status      = STAT_FULL;
                                res_next.match_count = '0;
                                res_next.string_done = req_in.last_byte;
                                if (req_in.last_byte)
                                begin
                                    broken_next  = 1'b0;
                                    ins_cur_next = '0;
                                end
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        REQ_BUILD:
                        begin
                            state_next = S_BLD_INIT;
                        end
                        REQ_QUERY:
                        begin
                            res_next.string_done = req_in.last_byte;
                            if (!built_reg)
                            begin
                                res_next.status      = STAT_NOT_BUILT;
                                res_next.match_count = '0;
                                state_next           = S_RESP;
                            end
                            else if (stopped_reg)
                            begin
                                res_next.status      = STAT_OK;
                                res_next.match_count = total_reg;
                                state_next           = S_RESP;
                                qclr                 = req_in.last_byte;
                            end
                            else
                            begin
                                f_next     = qry_cur_reg;
                                state_next = S_Q_WALK;
                            end
                        end
                        default:
                        begin
                            res_next.status      = STAT_OK;
                            res_next.match_count = '0;
                            res_next.string_done = 1'b0;
                            state_next           = S_RESP;
                        end
                    endcase
                end
            end

            S_INS_RD:
            begin
                cm_node    = ins_cur_reg;
                ch_re      = 1'b1;
                state_next = S_INS_CHK;
            end

            S_INS_CHK:
            begin
                cm_node              = ins_cur_reg;
                res_next.status      = STAT_OK;
                res_next.match_count = '0;
                res_next.string_done = req_reg.last_byte;
                if (child_q == '0 && nodes_reg >= NODES_FULL)
                begin
                    res_next.status = STAT_FULL;
                    if (req_reg.last_byte)
                    begin
                        ins_cur_next = '0;
                    end
                    else
                    begin
                        broken_next = 1'b1;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    if (child_q == '0)
                    begin
                        ch_we      = 1'b1;
                        ch_wdata   = nx;
                        nodes_next = nodes_reg + (NW+1)'(1);
                    end
                    ins_cur_next = nx;
                    if (req_reg.last_byte)
                    begin
                        nd_re      = 1'b1;
                        nd_raddr   = nx;
                        state_next = S_INS_CNT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_INS_CNT:
            begin
                nd_we.cnt    = 1'b1;
                nd_waddr     = ins_cur_reg;
                nd_wdata.cnt = cnt_inc;
                ins_cur_next = '0;
                state_next   = S_RESP;
            end

            S_BLD_INIT:
            begin
                nd_we.fail = 1'b1;
                nd_we.qent = 1'b1;
                nd_waddr   = '0;
                head_next  = '0;
                tail_next  = (NW+1)'(1);
                state_next = S_BLD_POP;
            end

            S_BLD_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next           = 1'b1;
                    res_next.status      = STAT_BUILT;
                    res_next.match_count = '0;
                    res_next.string_done = 1'b0;
                    qclr                 = 1'b1;
                    state_next           = S_RESP;
                end
                else
                begin
                    nd_re      = 1'b1;
                    nd_raddr   = head_reg[NW-1:0];
                    head_next  = head_reg + (NW+1)'(1);
                    state_next = S_BLD_NODE;
                end
            end

            S_BLD_NODE:
            begin
                bnode_next = node_q.qent;
                nd_re      = 1'b1;
                nd_raddr   = node_q.qent;
                c_next     = '0;
                state_next = S_BLD_FL;
            end

            S_BLD_FL:
            begin
                fnode_next = node_q.fail;
                state_next = S_BLD_KID;
            end

            S_BLD_KID:
            begin
                if (c_reg == SYM_END)
                begin
                    state_next = S_BLD_POP;
                end
                else
                begin
                    cm_node    = bnode_reg;
                    cm_sym     = c_reg[SW-1:0];
                    ch_re      = 1'b1;
                    state_next = S_BLD_KIDD;
                end
            end

            S_BLD_KIDD:
            begin
                if (child_q == '0)
                begin
                    c_next     = c_reg + (SW+1)'(1);
                    state_next = S_BLD_KID;
                end
                else
                begin
                    ch_next = child_q;
                    if (bnode_reg == '0)
                    begin
                        tgt_next   = '0;
                        state_next = S_BLD_SETF;
                    end
                    else
                    begin
                        f_next     = fnode_reg;
                        state_next = S_BLD_WALK;
                    end
                end
            end

            S_BLD_WALK:
            begin
                cm_sym     = c_reg[SW-1:0];
                ch_re      = 1'b1;
                state_next = (f_reg == '0) ? S_BLD_TGT : S_BLD_WALKD;
            end

            S_BLD_WALKD:
            begin
                if (child_q != '0)
                begin
                    tgt_next   = child_q;
                    state_next = S_BLD_SETF;
                end
                else
                begin
                    nd_re      = 1'b1;
                    state_next = S_BLD_WALKF;
                end
            end

            S_BLD_WALKF:
            begin
                f_next     = node_q.fail;
                state_next = S_BLD_WALK;
            end

            S_BLD_TGT:
            begin
                tgt_next   = child_q;
                state_next = S_BLD_SETF;
            end

            S_BLD_SETF:
            begin
                nd_we.fail    = 1'b1;
                nd_waddr      = ch_reg;
                nd_wdata.fail = tgt_reg;
                state_next    = S_BLD_PUSH;
            end

            S_BLD_PUSH:
            begin
                if (tail_reg < NODES_FULL)
                begin
                    nd_we.qent    = 1'b1;
                    nd_waddr      = tail_reg[NW-1:0];
                    nd_wdata.qent = ch_reg;
                    tail_next     = tail_reg + (NW+1)'(1);
                end
                c_next     = c_reg + (SW+1)'(1);
                state_next = S_BLD_KID;
            end

            S_Q_WALK:
            begin
                ch_re      = 1'b1;
                state_next = (f_reg == '0) ? S_Q_GOT : S_Q_WD;
            end

            S_Q_WD:
            begin
                if (child_q != '0)
                begin
                    f_next       = child_q;
                    qry_cur_next = child_q;
                    state_next   = S_Q_T;
                end
                else
                begin
                    nd_re      = 1'b1;
                    state_next = S_Q_WF;
                end
            end

            S_Q_WF:
            begin
                f_next     = node_q.fail;
                state_next = S_Q_WALK;
            end

            S_Q_GOT:
            begin
                f_next       = child_q;
                qry_cur_next = child_q;
                state_next   = S_Q_T;
            end

            S_Q_T:
            begin
                if (f_reg == '0)
                begin
                    res_next.status      = STAT_OK;
                    res_next.match_count = total_reg;
                    res_next.string_done = req_reg.last_byte;
                    qclr                 = req_reg.last_byte;
                    state_next           = S_RESP;
                end
                else
                begin
                    nd_re      = 1'b1;
                    state_next = S_Q_TD;
                end
            end

            S_Q_TD:
            begin
                res_next.status      = STAT_OK;
                res_next.string_done = req_reg.last_byte;
                if (node_q.tag == epoch_reg)
                begin
                    // rest of the output chain already counted in this string
                    res_next.match_count = total_reg;
                    qclr                 = req_reg.last_byte;
                    state_next           = S_RESP;
                end
                else
                begin
                    total_next   = tot_sat;
                    nd_we.tag    = 1'b1;
                    nd_wdata.tag = epoch_reg;
                    f_next       = node_q.fail;
                    if (stop_at_first && tot_sat != '0)
                    begin
                        stopped_next         = 1'b1;
                        res_next.match_count = tot_sat;
                        qclr                 = req_reg.last_byte;
                        state_next           = S_RESP;
                    end
                    else
                    begin
                        state_next = S_Q_T;
                    end
                end
            end

            S_SWEEP:
            begin
                nd_we.tag = 1'b1;
                nd_waddr  = clr_reg[NW-1:0];
                if (clr_reg == SWEEP_LAST)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    clr_next = clr_reg + CAW'(1);
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of string or build: marks drop by moving to a fresh tag, sweep on wrap
        if (qclr)
        begin
            qry_cur_next = '0;
            total_next   = '0;
            stopped_next = 1'b0;
            if (epoch_reg == TAG_LAST)
            begin
                epoch_next = TAG_FIRST;
                clr_next   = '0;
                state_next = S_SWEEP;
            end
            else
            begin
                epoch_next = epoch_reg + TAG_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            ins_cur_reg <= '0;
            qry_cur_reg <= '0;
            nodes_reg   <= (NW+1)'(1);
            total_reg   <= '0;
            built_reg   <= 1'b0;
            stopped_reg <= 1'b0;
            broken_reg  <= 1'b0;
            epoch_reg   <= TAG_FIRST;
            head_reg    <= '0;
            tail_reg    <= '0;
            c_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            ins_cur_reg <= ins_cur_next;
            qry_cur_reg <= qry_cur_next;
            nodes_reg   <= nodes_next;
            total_reg   <= total_next;
            built_reg   <= built_next;
            stopped_reg <= stopped_next;
            broken_reg  <= broken_next;
            epoch_reg   <= epoch_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            c_reg       <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        sym_reg   <= sym_next;
        res_reg   <= res_next;
        f_reg     <= f_next;
        bnode_reg <= bnode_next;
        fnode_reg <= fnode_next;
        ch_reg    <= ch_next;
        tgt_reg   <= tgt_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res_out   = res_reg;

endmodule

`default_nettype wire

>>> rtl/aho_corasick_keyword_matcher.sv
// Keyword matcher: a trie of keywords in a child table and a node table, failure links
// built breadth first, text bytes matched with goto and failure steps. After reset the
// block clears its child table before it takes a word. An insert reads the child table,
// adds a missing child and on a keyword's last byte raises that node's count; a query
// byte takes failure steps until the goto hits or the root is reached, then walks the
// output chain; a dropped keyword byte, a query before a build, a byte of a stopped
// string or an unknown request goes straight to its result. A build gives each child
// its failure link and a place in the queue. Every 255th string end or build adds a pass
// over the match marks of all MAX_NODES nodes. Each word is finished before the next is
// taken; a finished result waits in an output register while the next word is taken.
// depends on acm_pkg and acm_engine
`default_nettype none

module aho_corasick_keyword_matcher
    import acm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,   // data_byte
    input  wire logic [1:0]        s_tuser,   // req_type
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [COUNT_W-1:0]     m_tdata,   // match_count
    output logic [1:0]             m_tuser,   // status
    output logic                   m_tlast,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);

    logic     stop_reg;
    logic     m_valid_reg, m_valid_next;
    acm_res_t m_res_reg;
    acm_req_t req;
    acm_res_t res;
    logic     res_valid, res_ready;

    assign req.req_type  = req_type_t'(s_tuser);
    assign req.data_byte = s_tdata;
    assign req.last_byte = s_tlast;

    acm_engine #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .stop_at_first (stop_reg),
        .req_valid     (s_tvalid),
        .req_ready     (s_tready),
        .req_in        (req),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res_out       (res)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            stop_reg <= cfg_data;
        end
    end

    // output register frees the engine as soon as the result is loaded
    assign res_ready    = !m_valid_reg || m_tready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.match_count;
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.string_done;

endmodule

`default_nettype wire

>>> rtl/acm_checker.sv
// port-level checks of the keyword matcher, bound to the top level
// depends on acm_pkg and aho_corasick_keyword_matcher
`default_nettype none

module acm_checker
    import acm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [COUNT_W-1:0] m_tdata,
    input wire logic [1:0]         m_tuser,
    input wire logic               m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_build_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_BUILT |-> m_tdata == '0 && !m_tlast)
        else $error("build word carries a count or end mark");

    a_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_NOT_BUILT || m_tuser == STAT_FULL) |-> m_tdata == '0)
        else $error("rejected word carries a count");

endmodule

bind aho_corasick_keyword_matcher acm_checker u_acm_checker (.*);

`default_nettype wire

>>> verif/acm_checker.sv
// checker for the keyword matcher: watches the request, result and config channels,
// predicts every result word from its own copy of the trie and compares in order
// depends on acm_pkg
`default_nettype none

module acm_tb_checker
    import acm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ALPHABET  = ALPHABET_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,
    input  wire logic [1:0]         s_tuser,
    input  wire logic               s_tlast,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [COUNT_W-1:0] m_tdata,
    input  wire logic [1:0]         m_tuser,
    input  wire logic               m_tlast,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic               cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    bit [15:0] trie_next [MAX_NODES*ALPHABET];
    bit [15:0] fail_to [MAX_NODES];
    bit [15:0] kw_hits [MAX_NODES];
    bit        counted [MAX_NODES];
    bit [15:0] bfs_fifo [MAX_NODES];
    int        node_total;
    int        ins_node;
    int        txt_node;
    int        str_total;
    bit        trie_ready;
    bit        str_stopped;
    bit        ins_dropped;
    bit        first_only;

    acm_res_t  expected_words [$];

    function automatic int child_of(int node, int sym);
        if (node >= MAX_NODES || sym >= ALPHABET) return 0;
        return trie_next[node*ALPHABET + sym];
    endfunction

    task automatic clear_string();
        txt_node    = 0;
        str_total   = 0;
        str_stopped = 0;
        for (int i = 0; i < MAX_NODES; i++) counted[i] = 0;
    endtask

    task automatic wipe_trie();
        for (int i = 0; i < MAX_NODES*ALPHABET; i++) trie_next[i] = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            fail_to[i] = 0;
            kw_hits[i] = 0;
        end
        node_total  = 1;
        ins_node    = 0;
        trie_ready  = 0;
        ins_dropped = 0;
        first_only  = 0;
        clear_string();
    endtask

    task automatic link_failures();
        int head;
        int tail;
        int node;
        int ch;
        int f;
        int guard;
        int target;
        head = 0;
        tail = 0;
        fail_to[0] = 0;
        bfs_fifo[tail++] = 0;
        while (head < tail)
        begin
            node = bfs_fifo[head++];
            for (int c = 0; c < ALPHABET; c++)
            begin
                ch = child_of(node, c);
                if (ch == 0 || ch >= MAX_NODES) continue;
                target = 0;
                if (node != 0)
                begin
                    f = fail_to[node];
                    guard = 0;
                    while (f != 0 && child_of(f, c) == 0 && guard < MAX_NODES)
                    begin
                        f = fail_to[f];
                        guard++;
                    end
                    target = child_of(f, c);
                end
                fail_to[ch] = 16'(target);
                if (tail < MAX_NODES) bfs_fifo[tail++] = 16'(ch);
            end
        end
    endtask

    // one request word in, one result word out
    task automatic match_step(input req_type_t req, input logic [7:0] data, input logic last,
                              output acm_res_t res);
        int sym;
        int cur;
        int nx;
        int p;
        int t;
        int guard;
        sym = int'(data) % ALPHABET;
        res.status      = STAT_OK;
        res.match_count = '0;
        res.string_done = 1'b0;
        case (req)
            REQ_INSERT:
            begin
                trie_ready = 0;
                res.string_done = last;
                if (!ins_dropped)
                begin
                    cur = ins_node < MAX_NODES ? ins_node : 0;
                    nx = child_of(cur, sym);
                    if (nx == 0)
                    begin
                        if (node_total >= MAX_NODES) ins_dropped = 1;
                        else
                        begin
                            nx = node_total++;
                            trie_next[cur*ALPHABET + sym] = 16'(nx);
                        end
                    end
                    if (!ins_dropped)
                    begin
                        ins_node = nx;
                        if (last && kw_hits[nx] != 16'hFFFF) kw_hits[nx]++;
                    end
                end
                if (ins_dropped) res.status = STAT_FULL;
                if (last)
                begin
                    ins_node = 0;
                    ins_dropped = 0;
                end
            end
            REQ_BUILD:
            begin
                link_failures();
                trie_ready = 1;
                clear_string();
                res.status = STAT_BUILT;
            end
            REQ_QUERY:
            begin
                res.string_done = last;
                if (!trie_ready) res.status = STAT_NOT_BUILT;
                else
                begin
                    if (!str_stopped)
                    begin
                        p = txt_node < MAX_NODES ? txt_node : 0;
                        guard = 0;
                        while (p != 0 && child_of(p, sym) == 0 && guard < MAX_NODES)
                        begin
                            p = fail_to[p];
                            guard++;
                        end
                        p = child_of(p, sym);
                        txt_node = p;
                        t = p;
                        guard = 0;
                        // walk the output chain, each keyword node counted once per string
                        while (t != 0 && t < MAX_NODES && !counted[t] && guard < MAX_NODES)
                        begin
                            str_total += kw_hits[t];
                            if (str_total > 65535) str_total = 65535;
                            counted[t] = 1;
                            t = fail_to[t];
                            guard++;
                            if (first_only && str_total != 0)
                            begin
                                str_stopped = 1;
                                break;
                            end
                        end
                    end
                    res.match_count = 16'(str_total);
                    if (last) clear_string();
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        acm_res_t want;
        acm_res_t got;
        if (!rst_n)
        begin
            wipe_trie();
            expected_words.delete();
            fail_count = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status      = status_t'(m_tuser);
                got.match_count = m_tdata;
                got.string_done = m_tlast;
                checked++;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: status %0d count %0d",
                           m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.match_count != want.match_count)
                    begin
                        $error("match_count: expected %0d actual %0d",
                               want.match_count, got.match_count);
                        fail_count++;
                    end
                    if (got.string_done != want.string_done)
                    begin
                        $error("string_done: expected %0d actual %0d",
                               want.string_done, got.string_done);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                match_step(req_type_t'(s_tuser), s_tdata, s_tlast, want);
                expected_words.push_back(want);
            end
            if (cfg_valid && cfg_ready) first_only = cfg_data;
            pending = expected_words.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/aho_corasick_keyword_matcher_tb.sv
// testbench top for the keyword matcher: clock, reset, request and config stimulus,
// result back-pressure and the verdict
// depends on acm_pkg, aho_corasick_keyword_matcher and acm_tb_checker
`default_nettype none

module aho_corasick_keyword_matcher_tb;
    import acm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  MAX_NODES  = MAX_NODES_DEF;
    localparam int  ALPHABET   = ALPHABET_DEF;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int  KW_SLOTS   = 64;
    localparam int  KW_MAXLEN  = 6;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic [1:0]        s_tuser;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [COUNT_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;

    int  fail_count;
    int  pending;
    int  checked;
    int  words_sent;
    int  burst_left;
    int  builds_done;
    bit  hold_req;
    bit  rx_always;
    longint cycles;

    logic [7:0] kw_bytes [KW_SLOTS][KW_MAXLEN];
    int         kw_len [KW_SLOTS];
    int         kw_num;

    aho_corasick_keyword_matcher #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET)) uut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    acm_tb_checker #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET)) u_checker
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: ready follows one of four patterns chosen anew at random, plus one long hold-off
    initial
    begin
        int rx_mode;
        int rx_phase;
        rx_mode  = 0;
        rx_phase = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 0;
            end
            else
            begin
                rx_phase++;
                if (rx_phase % 256 == 0) rx_mode = $urandom_range(0, 3);
                if (rx_always) m_tready = 1'b1;
                else
                    case (rx_mode)
                        0: m_tready = 1'b1;
                        1: m_tready = ($urandom_range(0, 3) != 0);
                        2: m_tready = ((rx_phase % 8) > 2);
                        default: m_tready = ($urandom_range(0, 1) != 0);
                    endcase
            end
        end
    end

    task automatic send_word(input req_type_t req, input logic [7:0] data, input logic last);
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
        end
        else
            @(negedge clk);
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = data;
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_first_only(input logic value);
        drain();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] text_byte();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(8'h61, 8'h64));
    endfunction

    task automatic insert_keyword();
        int n;
        int slot;
        logic [7:0] b;
        n = $urandom_range(1, KW_MAXLEN);
        if (kw_num < KW_SLOTS)
        begin
            slot = kw_num;
            kw_num = kw_num + 1;
        end
        else
            slot = $urandom_range(0, KW_SLOTS-1);
        kw_len[slot] = n;
        for (int i = 0; i < n; i++)
        begin
            b = text_byte();
            kw_bytes[slot][i] = b;
            send_word(REQ_INSERT, b, i == n-1);
        end
    endtask

    // text mostly built from keyword pieces so the failure walks get exercised
    task automatic query_string(input int frags);
        int k;
        int from;
        logic [7:0] b;
        for (int f = 0; f < frags; f++)
        begin
            if (kw_num != 0 && $urandom_range(0, 3) != 0)
            begin
                k = $urandom_range(0, kw_num-1);
                from = $urandom_range(0, kw_len[k]-1);
                for (int i = from; i < kw_len[k]; i++)
                    send_word(REQ_QUERY, kw_bytes[k][i], (f == frags-1) && (i == kw_len[k]-1));
            end
            else
            begin
                b = text_byte();
                send_word(REQ_QUERY, b, f == frags-1);
            end
        end
    endtask

    initial
    begin
        int nkw;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = REQ_NONE;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 1'b0;
        hold_req   = 0;
        rx_always  = 0;
        words_sent = 0;
        burst_left = 0;
        builds_done = 0;
        kw_num     = 0;
        rst_n      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: not built, unknown request, extreme bytes, insert after build, stop mode
        write_first_only(1'b0);
        send_word(REQ_QUERY, 8'h00, 1'b1);
        send_word(REQ_NONE, 8'hFF, 1'b1);
        send_word(REQ_INSERT, 8'hFF, 1'b1);
        send_word(REQ_INSERT, 8'h00, 1'b0);
        send_word(REQ_INSERT, 8'hFF, 1'b1);
        send_word(REQ_INSERT, 8'hFF, 1'b0);
        send_word(REQ_INSERT, 8'hFF, 1'b1);
        send_word(REQ_BUILD, 8'h00, 1'b0);
        send_word(REQ_QUERY, 8'h00, 1'b0);
        send_word(REQ_QUERY, 8'hFF, 1'b0);
        send_word(REQ_QUERY, 8'hFF, 1'b0);
        send_word(REQ_QUERY, 8'hFF, 1'b1);
        send_word(REQ_INSERT, 8'h00, 1'b1);
        send_word(REQ_QUERY, 8'h00, 1'b1);
        send_word(REQ_BUILD, 8'hFF, 1'b1);
        send_word(REQ_QUERY, 8'h00, 1'b1);
        write_first_only(1'b1);
        send_word(REQ_QUERY, 8'h00, 1'b0);
        send_word(REQ_QUERY, 8'hFF, 1'b0);
        send_word(REQ_QUERY, 8'hFF, 1'b0);
        send_word(REQ_QUERY, 8'hFF, 1'b1);
        builds_done += 2;

        // random phases: grow the dictionary, rebuild, run text against it
        for (int ph = 0; ph < 12; ph++)
        begin
            write_first_only(ph % 3 == 1 ? 1'b1 : (ph % 3 == 2 ? 1'($urandom) : 1'b0));
            nkw = $urandom_range(1, 4);
            for (int i = 0; i < nkw; i++) insert_keyword();
            if ($urandom_range(0, 2) == 0) query_string(2);
            send_word(REQ_BUILD, 8'($urandom), 1'($urandom));
            builds_done++;
            if (ph == 4) hold_req = 1;
            while (words_sent < 20 + 70 * (ph + 1))
            begin
                case ($urandom_range(0, 19))
                    0: send_word(REQ_NONE, 8'($urandom), 1'($urandom));
                    1: send_word(REQ_QUERY, 8'($urandom), 1'($urandom));
                    default: query_string($urandom_range(1, 6));
                endcase
            end
            if (ph == 7)
            begin
                // insert mid-phase drops the built state, then rebuild
                insert_keyword();
                query_string(2);
                send_word(REQ_BUILD, 8'h00, 1'b0);
                builds_done++;
                query_string(4);
            end
        end

        // fill the node table; the tail of the keyword and a fresh one are dropped
        drain();
        rx_always = 1;
        for (int i = 0; i < MAX_NODES + 8; i++)
            send_word(REQ_INSERT, 8'($urandom), i == MAX_NODES + 7);
        send_word(REQ_INSERT, 8'h5A, 1'b0);
        send_word(REQ_INSERT, 8'h3C, 1'b1);
        send_word(REQ_INSERT, 8'hFF, 1'b1);
        send_word(REQ_QUERY, 8'hFF, 1'b1);
        rx_always = 0;

        drain();
        repeat (2000) @(posedge clk);
        $display("run: %0d request words and %0d result words checked", words_sent, checked);
        $display("run: %0d builds, both match modes, long output stall, full node table",
                 builds_done);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/acm_pkg.sv
rtl/acm_engine.sv
rtl/aho_corasick_keyword_matcher.sv
rtl/acm_checker.sv
verif/acm_checker.sv
verif/aho_corasick_keyword_matcher_tb.sv
